// File: hw/rtl/bxq_pkg.sv
// Shared field widths and command codes for the binary trie xor query core.
`timescale 1ns / 1ps

package bxq_pkg;

	// Fixed widths of the command channel fields
	localparam int FIELD_W = 30;
	localparam int CMD_W   = 3;

	typedef logic [CMD_W-1:0]   cmd_t;
	typedef logic [FIELD_W-1:0] field_t;

	// Command codes
	localparam cmd_t CMD_INSERT  = 3'd0;
	localparam cmd_t CMD_ERASE   = 3'd1;
	localparam cmd_t CMD_MAX_XOR = 3'd2;
	localparam cmd_t CMD_MIN_XOR = 3'd3;
	localparam cmd_t CMD_CNT_LT  = 3'd4;
	localparam cmd_t CMD_CLEAR   = 3'd5;

endpackage

// File: hw/rtl/bxq_node_ram.sv
// Trie node store: one write port and one registered read port.
`timescale 1ns / 1ps

module bxq_node_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/binary_trie_xor_query_core.sv
// Top level of the binary trie xor query core: command sequencer around the node store.
// The core keeps a multiset of KEY_BITS-bit keys in a binary trie in one node RAM and
// takes one command at a time: a transaction is accepted when start is high and busy is
// low, and its result appears on result/ok/empty_res for exactly one cycle with done
// high, in the cycle after the command finishes; the receiver cannot stall it, so capture
// it when done is seen. Every node visit is one read of the single RAM read port, so
// the walk of the trie sets how long a command takes: clear, unknown commands, an insert
// into a full set and queries on an empty set finish when accepted, without a walk;
// max/min xor and count below limit walk down the trie from the root; erase makes
// a presence check with a live test per level, then a pass that lowers the counts;
// insert makes a pass that sizes the missing path, then a read-modify-write pass.
// No clearing pass runs after reset: the root reads as empty until first written,
// and other nodes are written when allocated.
`timescale 1ns / 1ps

module binary_trie_xor_query_core #(
	parameter int KEY_BITS      = 30,
	parameter int NODE_CAPACITY = 65536,
	parameter int COUNT_BITS    = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bxq_pkg::cmd_t     cmd,
	input  bxq_pkg::field_t   value,
	input  bxq_pkg::field_t   limit,
	output logic              done,
	output bxq_pkg::field_t   result,
	output logic              ok,
	output logic              empty_res
);

	localparam int FIELD_W = bxq_pkg::FIELD_W;
	localparam int PTR_W   = $clog2(NODE_CAPACITY);
	localparam int NF_W    = $clog2(NODE_CAPACITY + 1);
	localparam int LVL_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int NEED_W  = $clog2(KEY_BITS + 1);
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KEY_BITS - 1);
	localparam logic [NF_W:0]    CAP_EXT = (NF_W + 1)'(NODE_CAPACITY);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS1 = 3'd1;
	localparam logic [2:0] S_INS2 = 3'd2;
	localparam logic [2:0] S_INSF = 3'd3;
	localparam logic [2:0] S_ERS  = 3'd4;
	localparam logic [2:0] S_XQ   = 3'd5;
	localparam logic [2:0] S_CQ   = 3'd6;

	typedef struct packed {
		logic [PTR_W-1:0]      k1;
		logic [PTR_W-1:0]      k0;
		logic [COUNT_BITS-1:0] cnt;
	} node_t;

	// control registers
	logic [2:0]            st_q, st_d;
	logic [LVL_W-1:0]      lvl_q, lvl_d;
	logic                  first_q, first_d;
	logic                  last_q, last_d;
	logic                  pass_q, pass_d;
	logic                  probe_q, probe_d;
	logic                  from_rd_q, from_rd_d;
	logic [NF_W-1:0]       nf_q, nf_d;
	logic [COUNT_BITS-1:0] tot_q, tot_d;
	logic                  root_vld_q;
	logic                  rd_zero_q;
	logic                  done_q;

	// payload registers
	logic [PTR_W-1:0]      cur_ptr_q, cur_ptr_d;
	logic [PTR_W-1:0]      alt_q, alt_d;
	logic [KEY_BITS-1:0]   xres_q, xres_d;
	logic [COUNT_BITS-1:0] acc_q, acc_d;
	logic [KEY_BITS-1:0]   key_q;
	logic [KEY_BITS-1:0]   lim_q;
	bxq_pkg::cmd_t         cmd_q;
	bxq_pkg::field_t       result_q;
	logic                  ok_q;
	logic                  empty_q;

	// RAM side
	logic                  ram_we, ram_re;
	logic [PTR_W-1:0]      ram_waddr, ram_raddr;
	logic [$bits(node_t)-1:0] ram_rdata;
	node_t                 rd_node, wr_node, view;

	// step logic
	logic                  accept;
	logic                  fin, fin_ok, fin_emp;
	bxq_pkg::field_t       fin_res;
	logic                  key_b, lim_b, want_max, pref, live, do_a;
	logic [LVL_W-1:0]      la;
	logic [PTR_W-1:0]      c_ptr, o_ptr;
	logic [PTR_W-1:0]      nf_ptr;
	logic [NEED_W-1:0]     need;
	logic [NF_W:0]         need_sum;

	assign busy   = (st_q != S_IDLE);
	assign accept = start && !busy;
	assign nf_ptr = nf_q[PTR_W-1:0];

	// root reads as empty until it is first written
	assign rd_node = rd_zero_q ? node_t'('0) : node_t'(ram_rdata);

	// insert pass two: current node is either a fresh read or a just allocated node
	always_comb begin
		if (from_rd_q) begin
			view     = rd_node;
			view.cnt = rd_node.cnt + COUNT_BITS'(cur_ptr_q != '0);
		end else begin
			view     = '0;
			view.cnt = COUNT_BITS'(1);
		end
	end

	bxq_node_ram #(
		.WIDTH($bits(node_t)),
		.DEPTH(NODE_CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_node),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// command sequencer: at most one node read per cycle, write-back of the node left behind
	always_comb begin
		st_d      = st_q;
		lvl_d     = lvl_q;
		first_d   = first_q;
		last_d    = last_q;
		pass_d    = pass_q;
		probe_d   = probe_q;
		from_rd_d = from_rd_q;
		nf_d      = nf_q;
		tot_d     = tot_q;
		cur_ptr_d = cur_ptr_q;
		alt_d     = alt_q;
		xres_d    = xres_q;
		acc_d     = acc_q;
		ram_we    = 1'b0;
		ram_waddr = cur_ptr_q;
		wr_node   = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		fin_emp   = 1'b0;
		fin_res   = '0;
		key_b     = 1'b0;
		lim_b     = 1'b0;
		want_max  = (cmd_q == bxq_pkg::CMD_MAX_XOR);
		pref      = 1'b0;
		live      = 1'b0;
		do_a      = 1'b0;
		la        = lvl_q;
		c_ptr     = '0;
		o_ptr     = '0;
		need      = '0;
		need_sum  = '0;

		case (st_q)
			S_IDLE: begin
				if (accept) begin
					lvl_d     = LVL_TOP;
					first_d   = 1'b1;
					last_d    = 1'b0;
					pass_d    = 1'b0;
					probe_d   = 1'b0;
					from_rd_d = 1'b1;
					cur_ptr_d = '0;
					xres_d    = '0;
					acc_d     = '0;
					case (cmd)
						bxq_pkg::CMD_INSERT: begin
							if (tot_q == '1) begin
								fin = 1'b1;
							end else begin
								ram_re = 1'b1;
								st_d   = S_INS1;
							end
						end
						bxq_pkg::CMD_ERASE: begin
							ram_re = 1'b1;
							st_d   = S_ERS;
						end
						bxq_pkg::CMD_MAX_XOR, bxq_pkg::CMD_MIN_XOR: begin
							if (tot_q == '0) begin
								fin     = 1'b1;
								fin_ok  = 1'b1;
								fin_emp = 1'b1;
							end else begin
								ram_re = 1'b1;
								st_d   = S_XQ;
							end
						end
						bxq_pkg::CMD_CNT_LT: begin
							if (tot_q == '0) begin
								fin     = 1'b1;
								fin_ok  = 1'b1;
								fin_emp = 1'b1;
							end else begin
								ram_re = 1'b1;
								st_d   = S_CQ;
							end
						end
						bxq_pkg::CMD_CLEAR: begin
							ram_we    = 1'b1;
							ram_waddr = '0;
							nf_d      = NF_W'(1);
							tot_d     = '0;
							fin       = 1'b1;
							fin_ok    = 1'b1;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end

			// insert, first pass: find where the path ends, then size the allocation
			S_INS1: begin
				key_b = key_q[lvl_q];
				c_ptr = key_b ? rd_node.k1 : rd_node.k0;
				if (c_ptr == '0 || lvl_q == '0) begin
					need     = (c_ptr == '0) ? (NEED_W'(lvl_q) + NEED_W'(1)) : '0;
					need_sum = {1'b0, nf_q} + (NF_W + 1)'(need);
					if (need_sum > CAP_EXT) begin
						fin = 1'b1;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = '0;
						cur_ptr_d = '0;
						from_rd_d = 1'b1;
						lvl_d     = LVL_TOP;
						st_d      = S_INS2;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = c_ptr;
					lvl_d     = lvl_q - 1'b1;
				end
			end

			// insert, second pass: link or descend, write back the node left behind
			S_INS2: begin
				key_b     = key_q[lvl_q];
				c_ptr     = key_b ? view.k1 : view.k0;
				ram_we    = 1'b1;
				ram_waddr = cur_ptr_q;
				wr_node   = view;
				if (c_ptr == '0) begin
					if (key_b) begin
						wr_node.k1 = nf_ptr;
					end else begin
						wr_node.k0 = nf_ptr;
					end
					cur_ptr_d = nf_ptr;
					from_rd_d = 1'b0;
					nf_d      = nf_q + NF_W'(1);
				end else begin
					ram_re    = 1'b1;
					ram_raddr = c_ptr;
					cur_ptr_d = c_ptr;
					from_rd_d = 1'b1;
				end
				if (lvl_q == '0) begin
					st_d = S_INSF;
				end else begin
					lvl_d = lvl_q - 1'b1;
				end
			end

			// insert: write back the leaf
			S_INSF: begin
				ram_we    = 1'b1;
				ram_waddr = cur_ptr_q;
				wr_node   = view;
				tot_d     = tot_q + COUNT_BITS'(1);
				fin       = 1'b1;
				fin_ok    = 1'b1;
			end

			// erase: pass zero checks each node is live, pass one lowers the counts
			S_ERS: begin
				if (!first_q && !pass_q && rd_node.cnt == '0) begin
					fin = 1'b1;
				end else begin
					if (!first_q && pass_q) begin
						ram_we      = 1'b1;
						ram_waddr   = cur_ptr_q;
						wr_node     = rd_node;
						wr_node.cnt = rd_node.cnt - COUNT_BITS'(1);
					end
					if (!first_q && last_q) begin
						if (!pass_q) begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							first_d   = 1'b1;
							last_d    = 1'b0;
							pass_d    = 1'b1;
							lvl_d     = LVL_TOP;
						end else begin
							tot_d  = tot_q - COUNT_BITS'(1);
							fin    = 1'b1;
							fin_ok = 1'b1;
						end
					end else begin
						key_b = key_q[lvl_q];
						c_ptr = key_b ? rd_node.k1 : rd_node.k0;
						if (c_ptr == '0) begin
							fin = 1'b1;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = c_ptr;
							cur_ptr_d = c_ptr;
							first_d   = 1'b0;
							last_d    = (lvl_q == '0);
							if (lvl_q != '0) begin
								lvl_d = lvl_q - 1'b1;
							end
						end
					end
				end
			end

			// max/min xor: probe the preferred child, fall back to the other one
			S_XQ: begin
				if (probe_q) begin
					live           = (rd_node.cnt != '0);
					xres_d[lvl_q]  = want_max ^ !live;
					if (lvl_q == '0) begin
						fin    = 1'b1;
						fin_ok = 1'b1;
					end else if (live) begin
						do_a = 1'b1;
						la   = lvl_q - 1'b1;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = alt_q;
						probe_d   = 1'b0;
						lvl_d     = lvl_q - 1'b1;
					end
				end else begin
					do_a = 1'b1;
				end
				if (do_a) begin
					key_b = key_q[la];
					pref  = key_b ^ want_max;
					c_ptr = pref ? rd_node.k1 : rd_node.k0;
					o_ptr = pref ? rd_node.k0 : rd_node.k1;
					if (c_ptr == '0) begin
						xres_d[la] = !want_max;
						if (la == '0) begin
							fin    = 1'b1;
							fin_ok = 1'b1;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = o_ptr;
							probe_d   = 1'b0;
							lvl_d     = la - 1'b1;
						end
					end else begin
						ram_re    = 1'b1;
						ram_raddr = c_ptr;
						alt_d     = o_ptr;
						probe_d   = 1'b1;
						lvl_d     = la;
					end
				end
			end

			// count below limit: on a set limit bit add the key-side subtree and follow the other side, else follow the key side
			S_CQ: begin
				if (probe_q) begin
					acc_d = acc_q + rd_node.cnt;
					if (alt_q == '0 || lvl_q == '0) begin
						fin    = 1'b1;
						fin_ok = 1'b1;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = alt_q;
						probe_d   = 1'b0;
						lvl_d     = lvl_q - 1'b1;
					end
				end else begin
					key_b = key_q[lvl_q];
					lim_b = lim_q[lvl_q];
					c_ptr = key_b ? rd_node.k1 : rd_node.k0;
					o_ptr = key_b ? rd_node.k0 : rd_node.k1;
					if (lim_b && c_ptr != '0) begin
						ram_re    = 1'b1;
						ram_raddr = c_ptr;
						alt_d     = o_ptr;
						probe_d   = 1'b1;
					end else if (lim_b) begin
						if (o_ptr == '0 || lvl_q == '0) begin
							fin    = 1'b1;
							fin_ok = 1'b1;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = o_ptr;
							lvl_d     = lvl_q - 1'b1;
						end
					end else begin
						if (c_ptr == '0 || lvl_q == '0) begin
							fin    = 1'b1;
							fin_ok = 1'b1;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = c_ptr;
							lvl_d     = lvl_q - 1'b1;
						end
					end
				end
			end

			default: begin
				st_d = S_IDLE;
			end
		endcase

		// finished transaction: pick the result word
		if (fin) begin
			st_d = S_IDLE;
			if (st_q == S_XQ) begin
				fin_res = FIELD_W'(xres_d);
			end else if (st_q == S_CQ) begin
				fin_res = FIELD_W'(acc_d);
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			lvl_q      <= '0;
			first_q    <= 1'b0;
			last_q     <= 1'b0;
			pass_q     <= 1'b0;
			probe_q    <= 1'b0;
			from_rd_q  <= 1'b0;
			nf_q       <= NF_W'(1);
			tot_q      <= '0;
			root_vld_q <= 1'b0;
			rd_zero_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			st_q      <= st_d;
			lvl_q     <= lvl_d;
			first_q   <= first_d;
			last_q    <= last_d;
			pass_q    <= pass_d;
			probe_q   <= probe_d;
			from_rd_q <= from_rd_d;
			nf_q      <= nf_d;
			tot_q     <= tot_d;
			done_q    <= fin;
			if (ram_we && ram_waddr == '0) begin
				root_vld_q <= 1'b1;
			end
			if (ram_re) begin
				rd_zero_q <= (ram_raddr == '0) && !root_vld_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cur_ptr_q <= cur_ptr_d;
		alt_q     <= alt_d;
		xres_q    <= xres_d;
		acc_q     <= acc_d;
		if (accept) begin
			key_q <= KEY_BITS'(value);
			lim_q <= KEY_BITS'(limit);
			cmd_q <= cmd;
		end
		if (fin) begin
			result_q <= fin_res;
			ok_q     <= fin_ok;
			empty_q  <= fin_emp;
		end
	end

	assign done      = done_q;
	assign result    = result_q;
	assign ok        = ok_q;
	assign empty_res = empty_q;

	// the sequencer never reads the entry it writes in the same cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("node RAM read and write hit the same entry");

	// allocation never runs past the node pool
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= NF_W'(NODE_CAPACITY))
		else $error("node allocation exceeded capacity");

	// the element total moves by one per transaction or drops to zero on clear
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(tot_q != $past(tot_q)) |->
		(tot_q == COUNT_BITS'($past(tot_q) + 1'b1) ||
		 tot_q == COUNT_BITS'($past(tot_q) - 1'b1) || tot_q == '0))
		else $error("element total changed by more than one");

	// an empty-set answer is a successful query with a zero result
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && empty_q) |-> (ok_q && result_q == '0))
		else $error("empty flag with a non-zero result or failed status");

endmodule

// File: bench/tb_binary_trie_xor_query_core.sv
// Self-checking bench for the binary trie xor query core: random and directed commands.
`timescale 1ns / 1ps

module tb_binary_trie_xor_query_core;

	localparam int KEY_BITS      = 30;
	localparam int NODE_CAP      = 65536;
	localparam int COUNT_BITS    = 20;
	localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 80;
	localparam int RANDOM_ITEMS   = 1250;
	localparam int SEGMENT_LEN    = 50;

	// Codes the core must ignore
	localparam bxq_pkg::cmd_t CMD_BAD_LO = 3'd6;
	localparam bxq_pkg::cmd_t CMD_BAD_HI = 3'd7;

	localparam bxq_pkg::field_t KEY_ONES = '1;

	typedef struct packed {
		bxq_pkg::field_t result;
		logic            ok;
		logic            empty_res;
	} outcome_t;

	typedef struct {
		bxq_pkg::cmd_t   cmd;
		bxq_pkg::field_t value;
		bxq_pkg::field_t limit;
		int              gap;
		bit              drain;
	} cmd_item_t;

	typedef struct {
		outcome_t        out;
		bxq_pkg::cmd_t   cmd;
		bxq_pkg::field_t value;
		bxq_pkg::field_t limit;
	} pending_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	bxq_pkg::cmd_t   cmd = bxq_pkg::CMD_INSERT;
	bxq_pkg::field_t value = '0;
	bxq_pkg::field_t limit = '0;
	logic            busy;
	logic            done;
	bxq_pkg::field_t result;
	logic            ok;
	logic            empty_res;

	binary_trie_xor_query_core #(
		.KEY_BITS(KEY_BITS),
		.NODE_CAPACITY(NODE_CAP),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.value(value),
		.limit(limit),
		.done(done),
		.result(result),
		.ok(ok),
		.empty_res(empty_res)
	);

	always #5 clk = ~clk;

	// Shadow trie: child links and pass-through counts per node
	int unsigned trie_kid [NODE_CAP][2];
	int unsigned trie_cnt [NODE_CAP];
	int unsigned trie_next;
	int unsigned trie_total;

	cmd_item_t cmd_backlog[$];
	pending_t  pending_results[$];

	int mismatches = 0;
	int n_insert = 0, n_erase = 0, n_query = 0, n_clear = 0, n_other = 0;
	int n_full_reject = 0, n_empty_query = 0, n_erase_miss = 0;

	function automatic void trie_reset();
		for (int i = 0; i < NODE_CAP; i++) begin
			trie_kid[i][0] = 0;
			trie_kid[i][1] = 0;
			trie_cnt[i] = 0;
		end
		trie_next = 1;
		trie_total = 0;
	endfunction

	function automatic bit trie_live(int unsigned n);
		return n != 0 && n < NODE_CAP && trie_cnt[n] > 0;
	endfunction

	function automatic bit trie_insert(bxq_pkg::field_t v);
		int unsigned u, c, need;
		int i;
		bit missing;
		if (trie_total >= COUNT_MAX)
			return 1'b0;
		// size the missing tail of the path
		u = 0;
		need = 0;
		missing = 1'b0;
		for (i = KEY_BITS - 1; i >= 0 && !missing; i--) begin
			c = trie_kid[u][v[i]];
			if (c == 0 || c >= NODE_CAP) begin
				need = i + 1;
				missing = 1'b1;
			end else begin
				u = c;
			end
		end
		if (longint'(trie_next) + need > NODE_CAP)
			return 1'b0;
		// allocate and raise counts
		u = 0;
		for (i = KEY_BITS - 1; i >= 0; i--) begin
			c = trie_kid[u][v[i]];
			if (c == 0 || c >= NODE_CAP) begin
				c = trie_next;
				trie_next++;
				trie_kid[c][0] = 0;
				trie_kid[c][1] = 0;
				trie_cnt[c] = 0;
				trie_kid[u][v[i]] = c;
			end
			u = c;
			trie_cnt[u]++;
		end
		trie_total++;
		return 1'b1;
	endfunction

	function automatic bit trie_erase(bxq_pkg::field_t v);
		int unsigned u;
		int i;
		u = 0;
		for (i = KEY_BITS - 1; i >= 0; i--) begin
			if (!trie_live(trie_kid[u][v[i]]))
				return 1'b0;
			u = trie_kid[u][v[i]];
		end
		u = 0;
		for (i = KEY_BITS - 1; i >= 0; i--) begin
			u = trie_kid[u][v[i]];
			trie_cnt[u]--;
		end
		trie_total--;
		return 1'b1;
	endfunction

	// Greedy walk: prefer the branch that sets (max) or clears (min) each xor bit
	function automatic bxq_pkg::field_t trie_extreme(bxq_pkg::field_t q, bit want_max);
		int unsigned u, c;
		bxq_pkg::field_t r;
		bit pref;
		u = 0;
		r = '0;
		for (int i = KEY_BITS - 1; i >= 0; i--) begin
			pref = want_max ? ~q[i] : q[i];
			c = trie_kid[u][pref];
			if (trie_live(c)) begin
				if (pref != q[i])
					r[i] = 1'b1;
				u = c;
			end else begin
				if (pref == q[i])
					r[i] = 1'b1;
				u = trie_kid[u][~pref];
				if (u >= NODE_CAP)
					u = 0;
			end
		end
		return r;
	endfunction

	// Walk along the limit; each set limit bit adds the whole subtree that keeps xor below it
	function automatic bxq_pkg::field_t trie_count_below(bxq_pkg::field_t q,
			bxq_pkg::field_t lim);
		int unsigned u, c;
		longint unsigned r;
		bit stop;
		u = 0;
		r = 0;
		stop = 1'b0;
		for (int i = KEY_BITS - 1; i >= 0 && !stop; i--) begin
			if (lim[i]) begin
				c = trie_kid[u][q[i]];
				if (c != 0 && c < NODE_CAP)
					r += trie_cnt[c];
				u = trie_kid[u][~q[i]];
			end else begin
				u = trie_kid[u][q[i]];
			end
			if (u == 0 || u >= NODE_CAP)
				stop = 1'b1;
		end
		return bxq_pkg::field_t'(r);
	endfunction

	function automatic outcome_t trie_apply(bxq_pkg::cmd_t c, bxq_pkg::field_t v,
			bxq_pkg::field_t lim);
		outcome_t o;
		o = '0;
		case (c)
			bxq_pkg::CMD_INSERT: o.ok = trie_insert(v);
			bxq_pkg::CMD_ERASE:  o.ok = trie_erase(v);
			bxq_pkg::CMD_MAX_XOR, bxq_pkg::CMD_MIN_XOR, bxq_pkg::CMD_CNT_LT: begin
				o.ok = 1'b1;
				if (trie_total == 0)
					o.empty_res = 1'b1;
				else if (c == bxq_pkg::CMD_CNT_LT)
					o.result = trie_count_below(v, lim);
				else
					o.result = trie_extreme(v, c == bxq_pkg::CMD_MAX_XOR);
			end
			bxq_pkg::CMD_CLEAR: begin
				trie_kid[0][0] = 0;
				trie_kid[0][1] = 0;
				trie_cnt[0] = 0;
				trie_next = 1;
				trie_total = 0;
				o.ok = 1'b1;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, pending_t p, bxq_pkg::field_t got,
			bxq_pkg::field_t want);
		$display("MISMATCH %s: cmd %0d value %h limit %h got %h want %h",
			what, p.cmd, p.value, p.limit, got, want);
		mismatches++;
	endtask

	wire xfer = start && !busy;

	// Driver: pulls pending commands, honors gaps and drain pauses
	cmd_item_t nxt;
	bit        nxt_loaded = 1'b0;
	int        gap_left = 0;

	always @(posedge clk) begin : drv
		outcome_t o;
		pending_t p;
		if (arst_n) begin
			if (xfer) begin
				o = trie_apply(cmd, value, limit);
				p.out = o;
				p.cmd = cmd;
				p.value = value;
				p.limit = limit;
				pending_results.push_back(p);
				case (cmd)
					bxq_pkg::CMD_INSERT: begin
						n_insert++;
						if (!o.ok && trie_total < COUNT_MAX)
							n_full_reject++;
					end
					bxq_pkg::CMD_ERASE: begin
						n_erase++;
						if (!o.ok)
							n_erase_miss++;
					end
					bxq_pkg::CMD_MAX_XOR, bxq_pkg::CMD_MIN_XOR, bxq_pkg::CMD_CNT_LT: begin
						n_query++;
						if (o.empty_res)
							n_empty_query++;
					end
					bxq_pkg::CMD_CLEAR: n_clear++;
					default:            n_other++;
				endcase
			end
			if (!start || xfer) begin
				if (!nxt_loaded && cmd_backlog.size() != 0) begin
					nxt = cmd_backlog.pop_front();
					nxt_loaded = 1'b1;
					gap_left = nxt.gap;
				end
				if (nxt_loaded && gap_left == 0 &&
						(!nxt.drain || pending_results.size() == 0)) begin
					start <= 1'b1;
					cmd <= nxt.cmd;
					value <= nxt.value;
					limit <= nxt.limit;
					nxt_loaded = 1'b0;
				end else begin
					start <= 1'b0;
					if (nxt_loaded && gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// Monitor: every done pulse carries one transaction result
	always @(posedge clk) begin : mon
		pending_t p;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				p.cmd = cmd;
				p.value = '0;
				p.limit = '0;
				p.out = '0;
				report_mismatch("result with no command outstanding", p, result, '0);
			end else begin
				p = pending_results.pop_front();
				if (result !== p.out.result)
					report_mismatch("result", p, result, p.out.result);
				if (ok !== p.out.ok)
					report_mismatch("ok", p, bxq_pkg::field_t'(ok),
						bxq_pkg::field_t'(p.out.ok));
				if (empty_res !== p.out.empty_res)
					report_mismatch("empty_res", p, bxq_pkg::field_t'(empty_res),
						bxq_pkg::field_t'(p.out.empty_res));
			end
		end
	end

	// Watchdog on cycles with no accepted transaction in either direction
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (xfer || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", idle_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Stimulus generation
	bxq_pkg::field_t live_keys[$];
	bxq_pkg::field_t narrow_base;

	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic bxq_pkg::field_t pick_key(bit narrow);
		int r;
		if (narrow)
			return narrow_base ^ bxq_pkg::field_t'($urandom_range(0, 31));
		r = $urandom_range(0, 99);
		if (r < 45 && live_keys.size() != 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		else if (r < 60 && live_keys.size() != 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)] ^
				(bxq_pkg::field_t'(1) << $urandom_range(0, KEY_BITS - 1));
		else if (r < 65)
			return '0;
		else if (r < 70)
			return KEY_ONES;
		else
			return bxq_pkg::field_t'($urandom);
	endfunction

	task automatic queue_cmd(bxq_pkg::cmd_t c, bxq_pkg::field_t v, bxq_pkg::field_t lim,
			int gap, bit drain);
		cmd_item_t it;
		while (cmd_backlog.size() >= 8)
			@(posedge clk);
		it.cmd = c;
		it.value = v;
		it.limit = lim;
		it.gap = gap;
		it.drain = drain;
		cmd_backlog.push_back(it);
	endtask

	task automatic gen_random(bit narrow, bit burst, bit drain);
		int r, lr;
		bxq_pkg::cmd_t c;
		bxq_pkg::field_t v, lim;
		r = $urandom_range(0, 99);
		v = pick_key(narrow);
		lim = bxq_pkg::field_t'($urandom);
		if (r < 34)
			c = bxq_pkg::CMD_INSERT;
		else if (r < 54)
			c = bxq_pkg::CMD_ERASE;
		else if (r < 66)
			c = bxq_pkg::CMD_MAX_XOR;
		else if (r < 78)
			c = bxq_pkg::CMD_MIN_XOR;
		else if (r < 95)
			c = bxq_pkg::CMD_CNT_LT;
		else if (r < 97)
			c = bxq_pkg::CMD_CLEAR;
		else if (r < 98)
			c = CMD_BAD_LO;
		else
			c = CMD_BAD_HI;
		if (c == bxq_pkg::CMD_ERASE && live_keys.size() != 0 && $urandom_range(0, 9) < 7)
			v = live_keys[$urandom_range(0, live_keys.size() - 1)];
		if (c == bxq_pkg::CMD_CNT_LT) begin
			lr = $urandom_range(0, 9);
			if (lr == 0)
				lim = '0;
			else if (lr == 1)
				lim = KEY_ONES;
			else if (lr < 5)
				lim = v ^ pick_key(narrow) ^ bxq_pkg::field_t'($urandom_range(0, 3));
		end
		// rough key tracking so erases and queries mostly hit stored keys
		case (c)
			bxq_pkg::CMD_INSERT: if (live_keys.size() < 200) live_keys.push_back(v);
			bxq_pkg::CMD_ERASE: begin
				for (int i = 0; i < live_keys.size(); i++) begin
					if (live_keys[i] == v) begin
						live_keys.delete(i);
						break;
					end
				end
			end
			bxq_pkg::CMD_CLEAR: live_keys.delete();
			default: ;
		endcase
		queue_cmd(c, v, lim, pick_gap(burst), drain);
	endtask

	task automatic run_random(int count);
		bit narrow, burst;
		for (int n = 0; n < count; n++) begin
			if (n % SEGMENT_LEN == 0) begin
				narrow = $urandom_range(0, 1);
				burst = ($urandom_range(0, 3) == 0);
				narrow_base = bxq_pkg::field_t'($urandom) & ~bxq_pkg::field_t'(31);
			end
			gen_random(narrow, burst, n % SEGMENT_LEN == 0 && $urandom_range(0, 2) == 0);
		end
	endtask

	initial begin
		trie_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty set, extremes, duplicates, dead paths, unknown codes, clear
		queue_cmd(bxq_pkg::CMD_MAX_XOR, KEY_ONES, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_MIN_XOR, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_CNT_LT, '0, KEY_ONES, 1, 1'b0);
		queue_cmd(bxq_pkg::CMD_ERASE, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_INSERT, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_INSERT, KEY_ONES, '0, 2, 1'b0);
		queue_cmd(bxq_pkg::CMD_INSERT, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_MAX_XOR, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_MIN_XOR, KEY_ONES, '0, 0, 1'b1);
		queue_cmd(bxq_pkg::CMD_MIN_XOR, '0, '0, 3, 1'b0);
		queue_cmd(bxq_pkg::CMD_CNT_LT, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_CNT_LT, '0, KEY_ONES, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_CNT_LT, KEY_ONES, KEY_ONES, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_ERASE, KEY_ONES, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_ERASE, KEY_ONES, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_MAX_XOR, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_ERASE, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_ERASE, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_ERASE, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_MAX_XOR, KEY_ONES, '0, 0, 1'b0);
		queue_cmd(CMD_BAD_LO, KEY_ONES, KEY_ONES, 0, 1'b0);
		queue_cmd(CMD_BAD_HI, bxq_pkg::field_t'($urandom), bxq_pkg::field_t'($urandom),
			0, 1'b0);
		queue_cmd(bxq_pkg::CMD_INSERT, bxq_pkg::field_t'(30'h2AAA_AAAA), '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_CLEAR, '0, '0, 0, 1'b0);
		queue_cmd(bxq_pkg::CMD_MIN_XOR, bxq_pkg::field_t'(30'h1555_5555), '0, 0, 1'b0);

		run_random(RANDOM_ITEMS);

		while (cmd_backlog.size() != 0 || nxt_loaded || start || pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d inserts (%0d refused on a full node pool), %0d erases (%0d absent),",
			n_insert, n_full_reject, n_erase, n_erase_miss);
		$display("%0d xor queries (%0d on an empty set), %0d clears, %0d unknown codes",
			n_query, n_empty_query, n_clear, n_other);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
